[src/pqbp_pkg.sv]
package pqbp_pkg;

  localparam int unsigned ColorW = 24;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned PlaneW = 8;
  localparam int unsigned SqW    = 2 * ChanW;
  // three squared channel differences summed
  localparam int unsigned DistW  = SqW + 2;
  localparam int unsigned NumPal = 4;
  localparam int unsigned PalIdxW = $clog2(NumPal);

  localparam int unsigned PixelsPerByteDef = 8;

  localparam logic [ColorW-1:0] PalZeroRst  = 24'hFFFFFF;
  localparam logic [ColorW-1:0] PalOneRst   = 24'h00FF00;
  localparam logic [ColorW-1:0] PalTwoRst   = 24'h000000;
  localparam logic [ColorW-1:0] PalThreeRst = 24'h0000FF;

  typedef enum logic [PalIdxW-1:0] {
    REG_PAL_ZERO  = 2'd0,
    REG_PAL_ONE   = 2'd1,
    REG_PAL_TWO   = 2'd2,
    REG_PAL_THREE = 2'd3
  } cfg_reg_e;

  typedef logic [DistW-1:0] dist_t;

  function automatic logic [SqW-1:0] chan_sq_diff(input logic [ChanW-1:0] a,
                                                  input logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return {{ChanW{1'b0}}, d} * {{ChanW{1'b0}}, d};
  endfunction

  function automatic dist_t color_dist(input logic [ColorW-1:0] p,
                                       input logic [ColorW-1:0] c);
    logic [SqW-1:0] r;
    logic [SqW-1:0] g;
    logic [SqW-1:0] b;
    r = chan_sq_diff(p[7:0], c[7:0]);
    g = chan_sq_diff(p[15:8], c[15:8]);
    b = chan_sq_diff(p[23:16], c[23:16]);
    return {2'b00, r} + {2'b00, g} + {2'b00, b};
  endfunction

endpackage

[src/palette_quantize_bitplane_pack.sv]
// Maps each 24-bit RGB pixel (red in bits 7:0) to the nearest of four palette
// colours by squared distance, lowest index winning a tie, and packs bit 0 and
// bit 1 of the chosen index into two plane bytes, first pixel in bit 0. Every
// PIXELS_PER_BYTE pixels one transfer carries both bytes; pixels beyond the
// eighth of a group only count towards its length. One pixel is taken per
// clock while in_stall_o is low. The path is three registers deep: input
// register, four parallel distance units feeding a distance register, then a
// compare tree and the plane accumulators feeding the output register. A
// group's bytes follow its last pixel through all three. Palette writes
// take effect at once and are meant for when the block is idle.
module palette_quantize_bitplane_pack
  import pqbp_pkg::*;
#(
  parameter int unsigned PIXELS_PER_BYTE = PixelsPerByteDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PalIdxW-1:0]  cfg_index_i,
  input  logic [ColorW-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ColorW-1:0]   pixel_color_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PlaneW-1:0]   plane_low_byte_o,
  output logic [PlaneW-1:0]   plane_high_byte_o
);

  localparam int unsigned PosW = $clog2(PIXELS_PER_BYTE);
  localparam logic [PosW-1:0] PosLast = PosW'(PIXELS_PER_BYTE - 1);

  logic [ColorW-1:0] pal_q [NumPal];

  logic              pix_valid_q;
  logic [ColorW-1:0] pix_q;
  logic              dist_valid_q;
  dist_t             dist_q [NumPal];
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PlaneW-1:0] acc_lo_q, acc_lo_d;
  logic [PlaneW-1:0] acc_hi_q, acc_hi_d;
  logic              out_valid_q, out_valid_d;
  logic [PlaneW-1:0] plane_lo_q, plane_hi_q;

  logic                out_free;
  logic                last_pix;
  logic                dist_take;
  logic                dist_load;
  logic                pix_load;
  logic [PalIdxW-1:0]  best01, best23, best;
  dist_t               min01, min23;
  logic [PlaneW-1:0]   pos_mask;
  logic [PlaneW-1:0]   lo_next, hi_next;

  // palette registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q[REG_PAL_ZERO]  <= PalZeroRst;
      pal_q[REG_PAL_ONE]   <= PalOneRst;
      pal_q[REG_PAL_TWO]   <= PalTwoRst;
      pal_q[REG_PAL_THREE] <= PalThreeRst;
    end else if (cfg_we_i) begin
      pal_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  // stage handshakes: each stage loads when empty or when it moves on
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_pix   = (pos_q == PosLast);
  assign dist_take  = dist_valid_q && (!last_pix || out_free);
  assign dist_load  = !dist_valid_q || dist_take;
  assign pix_load   = !pix_valid_q || dist_load;
  assign in_stall_o = !pix_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q  <= 1'b0;
      dist_valid_q <= 1'b0;
    end else begin
      if (pix_load) begin
        pix_valid_q <= in_valid_i;
      end
      if (dist_load) begin
        dist_valid_q <= pix_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_load && in_valid_i) begin
      pix_q <= pixel_color_i;
    end
  end

  // four distance units in parallel
  always_ff @(posedge clk_i) begin
    if (dist_load && pix_valid_q) begin
      for (int i = 0; i < NumPal; i++) begin
        dist_q[i] <= color_dist(pix_q, pal_q[i]);
      end
    end
  end

  // compare tree; strict less-than keeps the lower index on a tie
  always_comb begin
    best01 = (dist_q[1] < dist_q[0]) ? PalIdxW'(1) : PalIdxW'(0);
    min01  = (dist_q[1] < dist_q[0]) ? dist_q[1] : dist_q[0];
    best23 = (dist_q[3] < dist_q[2]) ? PalIdxW'(3) : PalIdxW'(2);
    min23  = (dist_q[3] < dist_q[2]) ? dist_q[3] : dist_q[2];
    best   = (min23 < min01) ? best23 : best01;
  end

  // one-hot bit for the current position, empty past the eighth pixel
  always_comb begin
    for (int k = 0; k < PlaneW; k++) begin
      pos_mask[k] = ({{(32-PosW){1'b0}}, pos_q} == 32'(k));
    end
  end

  always_comb begin
    lo_next = acc_lo_q | (pos_mask & {PlaneW{best[0]}});
    hi_next = acc_hi_q | (pos_mask & {PlaneW{best[1]}});
    pos_d       = pos_q;
    acc_lo_d    = acc_lo_q;
    acc_hi_d    = acc_hi_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (dist_take) begin
      if (last_pix) begin
        pos_d       = '0;
        acc_lo_d    = '0;
        acc_hi_d    = '0;
        out_valid_d = 1'b1;
      end else begin
        pos_d    = pos_q + PosW'(1);
        acc_lo_d = lo_next;
        acc_hi_d = hi_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      acc_lo_q    <= '0;
      acc_hi_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      acc_lo_q    <= acc_lo_d;
      acc_hi_q    <= acc_hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_take && last_pix) begin
      plane_lo_q <= lo_next;
      plane_hi_q <= hi_next;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign plane_low_byte_o  = plane_lo_q;
  assign plane_high_byte_o = plane_hi_q;

endmodule
